### rtl/ssi_pkg.sv
// Package for the segment against sphere test: widths, codes and payload types.
// Used by every module of the block but ssi_fifo; depends on nothing.
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int CW     = 24;          // coordinate width
    localparam int RW     = 2 * CW - 1;  // squared radius and distance width
    localparam int DW     = CW + 1;      // coordinate difference width
    localparam int PW     = 2 * DW;      // product of two differences
    localparam int SW     = PW + 2;      // sum of three products
    localparam int T_BITS = 16;          // fraction bits of the line parameter
    localparam int TW     = T_BITS + 1;  // line parameter width, 0..1 inclusive
    localparam int MW     = DW + TW + 1; // difference times parameter

    localparam int IDXW = 2;
    localparam logic [IDXW-1:0] REG_CX = 2'd0;
    localparam logic [IDXW-1:0] REG_CY = 2'd1;
    localparam logic [IDXW-1:0] REG_CZ = 2'd2;
    localparam logic [IDXW-1:0] REG_R2 = 2'd3;

    localparam logic [1:0] OUT_HIT = 2'd0;
    localparam logic [1:0] OUT_POS = 2'd1;
    localparam logic [1:0] OUT_NEG = 2'd2;

    localparam int QUEUE_DEPTH  = 4;
    localparam int RESULT_DEPTH = 32;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           outcome;
        logic signed [CW-1:0] contact_x;
        logic signed [CW-1:0] contact_y;
        logic signed [CW-1:0] contact_z;
    } t_out_item;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic [RW-1:0]        r2;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sz;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] dz;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
    } t_seg_item;

endpackage

### rtl/ssi_fifo.sv
// Small show-ahead register queue with push/pop handshakes and a fill count.
// Generic; depends on nothing.
`timescale 1ns / 1ps

module ssi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CNW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/ssi_front.sv
// Front end: accepts segments, forms edge and start-to-centre vectors, queues them.
// Depends on ssi_pkg and ssi_fifo.
`timescale 1ns / 1ps

module ssi_front #(
    parameter int QUEUE_DEPTH = ssi_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssi_pkg::t_cfg     i_cfg,
    input  logic              i_push,
    input  ssi_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_take,
    output ssi_pkg::t_seg_item o_seg,
    output logic              o_avail
);

    localparam int DW = ssi_pkg::DW;

    ssi_pkg::t_seg_item n_seg;
    logic [$bits(ssi_pkg::t_seg_item)-1:0] q_data;
    logic q_empty;

    always_comb begin
        n_seg.sx = i_item.start_x;
        n_seg.sy = i_item.start_y;
        n_seg.sz = i_item.start_z;
        n_seg.dx = DW'(i_item.end_x) - DW'(i_item.start_x);
        n_seg.dy = DW'(i_item.end_y) - DW'(i_item.start_y);
        n_seg.dz = DW'(i_item.end_z) - DW'(i_item.start_z);
        n_seg.qx = DW'(i_cfg.cx) - DW'(i_item.start_x);
        n_seg.qy = DW'(i_cfg.cy) - DW'(i_item.start_y);
        n_seg.qz = DW'(i_cfg.cz) - DW'(i_item.start_z);
    end

    ssi_fifo #(
        .WIDTH($bits(ssi_pkg::t_seg_item)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (n_seg),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count ()
    );

    assign o_seg   = ssi_pkg::t_seg_item'(q_data);
    assign o_avail = !q_empty;

endmodule

### rtl/ssi_back.sv
// Back end: dot products, pipelined restoring divider for the line parameter,
// closest point, saturated squared distance and side test. Depends on ssi_pkg.
`timescale 1ns / 1ps

module ssi_back #(
    parameter int RESULT_DEPTH = ssi_pkg::RESULT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssi_pkg::t_cfg                      i_cfg,
    input  ssi_pkg::t_seg_item                 i_seg,
    input  logic                               i_avail,
    output logic                               o_take,
    input  logic [$clog2(RESULT_DEPTH+1)-1:0]  i_out_count,
    output logic                               o_valid,
    output ssi_pkg::t_out_item                 o_result
);

    localparam int CW     = ssi_pkg::CW;
    localparam int RW     = ssi_pkg::RW;
    localparam int DW     = ssi_pkg::DW;
    localparam int PW     = ssi_pkg::PW;
    localparam int SW     = ssi_pkg::SW;
    localparam int T_BITS = ssi_pkg::T_BITS;
    localparam int TW     = ssi_pkg::TW;
    localparam int MW     = ssi_pkg::MW;
    localparam int CNW    = $clog2(RESULT_DEPTH + 1);
    localparam logic [RW-1:0] RMAX = {RW{1'b1}};
    localparam logic signed [MW:0] RND_HALF = (MW+1)'(1) <<< (T_BITS - 1);

    // Credit check: every item in flight has a reserved slot in the result queue.
    logic [CNW-1:0] r_inflight;
    logic [CNW:0]   used;

    assign used   = (CNW+1)'(r_inflight) + (CNW+1)'(i_out_count);
    assign o_take = i_avail && (used < (CNW+1)'(RESULT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (o_take && !o_valid) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (o_valid && !o_take) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // Stage 1: products
    logic                 r1_v;
    logic signed [CW-1:0] r1_s [3];
    logic signed [DW-1:0] r1_d [3];
    logic signed [PW-1:0] r1_pdq [3];
    logic signed [PW-1:0] r1_pdd [3];
    logic signed [PW-1:0] r1_cra, r1_crb;

    // Stage 2: sums
    logic                 r2_v;
    logic signed [CW-1:0] r2_s [3];
    logic signed [DW-1:0] r2_d [3];
    logic signed [SW-1:0] r2_num;
    logic [SW-1:0]        r2_den;
    logic                 r2_pos;

    // Divider stages, index 0 holds the classified item
    logic                 r_dv_v    [0:T_BITS];
    logic [SW-1:0]        r_dv_r    [0:T_BITS];
    logic [T_BITS-1:0]    r_dv_q    [0:T_BITS];
    logic [SW-1:0]        r_dv_den  [0:T_BITS];
    logic                 r_dv_zero [0:T_BITS];
    logic                 r_dv_one  [0:T_BITS];
    logic                 r_dv_pos  [0:T_BITS];
    logic signed [CW-1:0] r_dv_s    [0:T_BITS][3];
    logic signed [DW-1:0] r_dv_d    [0:T_BITS][3];

    // Stage A: scaled edge, B: closest point, C: squares, D: result
    logic                 r_a_v, r_b_v, r_c_v;
    logic                 r_a_pos, r_b_pos, r_c_pos;
    logic signed [MW-1:0] r_a_m [3];
    logic signed [CW-1:0] r_a_s [3];
    logic signed [CW-1:0] r_b_k [3];
    logic signed [CW-1:0] r_c_k [3];
    logic [RW-1:0]        r_c_sq [3];
    logic                 r_o_v;
    ssi_pkg::t_out_item   r_o_res;

    logic signed [DW-1:0] seg_d [3];
    logic signed [DW-1:0] seg_q [3];
    logic signed [CW-1:0] seg_s [3];
    logic [TW-1:0]        a_t;
    logic signed [MW:0]   b_w  [3];
    logic signed [MW:0]   b_sh [3];
    logic signed [CW-1:0] cen  [3];
    logic signed [DW-1:0] c_df [3];
    logic [DW-1:0]        c_mg [3];
    logic [PW-1:0]        c_sq [3];
    logic [RW:0]          d_sum1, d_sum2;
    logic [RW-1:0]        d_sat1, d_sat2;
    logic                 d_hit;

    assign seg_s = '{i_seg.sx, i_seg.sy, i_seg.sz};
    assign seg_d = '{i_seg.dx, i_seg.dy, i_seg.dz};
    assign seg_q = '{i_seg.qx, i_seg.qy, i_seg.qz};
    assign cen   = '{i_cfg.cx, i_cfg.cy, i_cfg.cz};

    // A clamped parameter of one is 1.0 exactly; num <= 0 clamps to zero.
    assign a_t = r_dv_zero[T_BITS] ? '0 :
                 r_dv_one[T_BITS]  ? {1'b1, {T_BITS{1'b0}}} :
                                     {1'b0, r_dv_q[T_BITS]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_w[i]  = (MW+1)'(r_a_m[i]) + RND_HALF;
            b_sh[i] = b_w[i] >>> T_BITS;
            c_df[i] = DW'(cen[i]) - DW'(r_b_k[i]);
            c_mg[i] = c_df[i][DW-1] ? DW'(-c_df[i]) : DW'(c_df[i]);
            c_sq[i] = PW'(c_mg[i]) * PW'(c_mg[i]);
        end
        d_sum1 = (RW+1)'(r_c_sq[0]) + (RW+1)'(r_c_sq[1]);
        d_sat1 = d_sum1[RW] ? RMAX : d_sum1[RW-1:0];
        d_sum2 = (RW+1)'(d_sat1) + (RW+1)'(r_c_sq[2]);
        d_sat2 = d_sum2[RW] ? RMAX : d_sum2[RW-1:0];
        d_hit  = d_sat2 < i_cfg.r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r1_v  <= o_take;
            r2_v  <= r1_v;
            r_a_v <= r_dv_v[T_BITS];
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_s[i]   <= seg_s[i];
            r1_d[i]   <= seg_d[i];
            r1_pdq[i] <= seg_d[i] * seg_q[i];
            r1_pdd[i] <= seg_d[i] * seg_d[i];
            r2_s[i]   <= r1_s[i];
            r2_d[i]   <= r1_d[i];
            r_a_m[i]  <= r_dv_d[T_BITS][i] * $signed({1'b0, a_t});
            r_a_s[i]  <= r_dv_s[T_BITS][i];
            r_b_k[i]  <= r_a_s[i] + $signed(b_sh[i][CW-1:0]);
            r_c_k[i]  <= r_b_k[i];
            r_c_sq[i] <= (c_sq[i] > PW'(RMAX)) ? RMAX : c_sq[i][RW-1:0];
        end
        r1_cra  <= i_seg.dz * i_seg.qx;
        r1_crb  <= i_seg.dx * i_seg.qz;
        r2_num  <= SW'(r1_pdq[0]) + SW'(r1_pdq[1]) + SW'(r1_pdq[2]);
        r2_den  <= SW'(r1_pdd[0]) + SW'(r1_pdd[1]) + SW'(r1_pdd[2]);
        r2_pos  <= r1_cra < r1_crb;
        r_a_pos <= r_dv_pos[T_BITS];
        r_b_pos <= r_a_pos;
        r_c_pos <= r_b_pos;
        if (d_hit) begin
            r_o_res.outcome   <= ssi_pkg::OUT_HIT;
            r_o_res.contact_x <= r_c_k[0];
            r_o_res.contact_y <= r_c_k[1];
            r_o_res.contact_z <= r_c_k[2];
        end else begin
            r_o_res.outcome   <= r_c_pos ? ssi_pkg::OUT_POS : ssi_pkg::OUT_NEG;
            r_o_res.contact_x <= '0;
            r_o_res.contact_y <= '0;
            r_o_res.contact_z <= '0;
        end
    end

    // Classification ahead of the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_zero[0] <= (r2_num <= 0);
        r_dv_one[0]  <= (r2_num > 0) && ($unsigned(r2_num) >= r2_den);
        r_dv_r[0]    <= $unsigned(r2_num);
        r_dv_q[0]    <= '0;
        r_dv_den[0]  <= r2_den;
        r_dv_pos[0]  <= r2_pos;
        r_dv_s[0]    <= r2_s;
        r_dv_d[0]    <= r2_d;
    end

    // One quotient bit per stage
    for (genvar j = 1; j <= T_BITS; j++) begin : g_div
        logic [SW:0] sh, df;
        logic        ge;

        assign sh = {r_dv_r[j-1], 1'b0};
        assign ge = sh >= {1'b0, r_dv_den[j-1]};
        assign df = sh - {1'b0, r_dv_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_r[j]    <= ge ? df[SW-1:0] : sh[SW-1:0];
            r_dv_q[j]    <= {r_dv_q[j-1][T_BITS-2:0], ge};
            r_dv_den[j]  <= r_dv_den[j-1];
            r_dv_zero[j] <= r_dv_zero[j-1];
            r_dv_one[j]  <= r_dv_one[j-1];
            r_dv_pos[j]  <= r_dv_pos[j-1];
            r_dv_s[j]    <= r_dv_s[j-1];
            r_dv_d[j]    <= r_dv_d[j-1];
        end
    end

    assign o_valid  = r_o_v;
    assign o_result = r_o_res;

endmodule

### rtl/segment_sphere_intersect.sv
// Segment against sphere test, top level: configuration registers, front end,
// back-end pipeline and result queue. Depends on ssi_pkg, ssi_front, ssi_back, ssi_fifo.
// Throughput: one segment per cycle while segments are queued and the result queue
// has a free slot, through the 23-stage back-end pipeline (16 divider stages).
// Reset: synchronous, active low; clears the configuration registers, the valid flags and both queues.
`timescale 1ns / 1ps

module segment_sphere_intersect #(
    parameter int QUEUE_DEPTH  = ssi_pkg::QUEUE_DEPTH,
    parameter int RESULT_DEPTH = ssi_pkg::RESULT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  ssi_pkg::t_in_item         i_item,
    output logic                      full,
    input  logic                      pop,
    output ssi_pkg::t_out_item        o_result,
    output logic                      empty,
    input  logic                      i_cfg_we,
    input  logic [ssi_pkg::IDXW-1:0]  i_cfg_idx,
    input  logic [ssi_pkg::RW-1:0]    i_cfg_data
);

    localparam int CW = ssi_pkg::CW;

    ssi_pkg::t_cfg      r_cfg;
    ssi_pkg::t_seg_item seg;
    logic               seg_avail, take;
    logic               res_valid;
    ssi_pkg::t_out_item res;
    logic [$bits(ssi_pkg::t_out_item)-1:0] res_data;
    logic [$clog2(RESULT_DEPTH+1)-1:0]     res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssi_pkg::REG_CX: r_cfg.cx <= i_cfg_data[CW-1:0];
                ssi_pkg::REG_CY: r_cfg.cy <= i_cfg_data[CW-1:0];
                ssi_pkg::REG_CZ: r_cfg.cz <= i_cfg_data[CW-1:0];
                ssi_pkg::REG_R2: r_cfg.r2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssi_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (take),
        .o_seg   (seg),
        .o_avail (seg_avail)
    );

    ssi_back #(
        .RESULT_DEPTH(RESULT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_seg       (seg),
        .i_avail     (seg_avail),
        .o_take      (take),
        .i_out_count (res_count),
        .o_valid     (res_valid),
        .o_result    (res)
    );

    ssi_fifo #(
        .WIDTH($bits(ssi_pkg::t_out_item)),
        .DEPTH(RESULT_DEPTH)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_result = ssi_pkg::t_out_item'(res_data);

endmodule

### rtl/ssi_checker.sv
// Port-level checks for the segment against sphere test, bound to the top level.
// Depends on ssi_pkg and segment_sphere_intersect.
`timescale 1ns / 1ps

module ssi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input ssi_pkg::t_out_item o_result
);

    // Both queues come out of reset empty: the result queue reports empty, the input queue not full.
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_not_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.outcome == ssi_pkg::OUT_HIT ||
                    o_result.outcome == ssi_pkg::OUT_POS ||
                    o_result.outcome == ssi_pkg::OUT_NEG))
        else $error("undefined outcome code");

    // A miss carries no contact point.
    a_miss_zero_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.outcome != ssi_pkg::OUT_HIT) |->
        (o_result.contact_x == '0 && o_result.contact_y == '0 &&
         o_result.contact_z == '0))
        else $error("contact point set on a miss");

endmodule

bind segment_sphere_intersect ssi_checker u_ssi_checker (.*);
